// ===== sv/ntns_pkg.sv =====
// Shared constants and types for the nearest tuning note search unit.
package ntns_pkg;

    localparam int NUM_NOTES_DEF = 128;
    localparam int FREQ_BITS_DEF = 32;
    localparam int NOTE_W        = 7;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Control that travels with an item from stage to stage.
    typedef struct packed {
        logic valid;
        logic oor;
    } t_ctl;

endpackage

// ===== sv/ntns_cell.sv =====
// One bisection cell: a private copy of the note table and one probe step.
module ntns_cell import ntns_pkg::*; #(
    parameter int NUM_NOTES = NUM_NOTES_DEF,
    parameter int FREQ_BITS = FREQ_BITS_DEF,
    localparam int IW = $clog2(NUM_NOTES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_wr_en,
    input  logic [IW-1:0]        i_wr_addr,
    input  logic [FREQ_BITS-1:0] i_wr_data,
    input  t_ctl                 i_ctl,
    input  logic [IW-1:0]        i_lo,
    input  logic [IW-1:0]        i_hi,
    input  logic [FREQ_BITS-1:0] i_x,
    output t_ctl                 o_ctl,
    output logic [IW-1:0]        o_lo,
    output logic [IW-1:0]        o_hi,
    output logic [FREQ_BITS-1:0] o_x
);

    logic [FREQ_BITS-1:0] mem [NUM_NOTES];

    logic [IW:0]          sum;
    logic [IW-1:0]        mid;
    logic                 act;
    t_ctl                 r_ctl;
    logic [IW-1:0]        r_lo;
    logic [IW-1:0]        r_hi;
    logic [IW-1:0]        r_mid;
    logic                 r_act;
    logic [FREQ_BITS-1:0] r_x;
    logic [FREQ_BITS-1:0] r_probe;
    logic                 step;
    logic                 go_hi;

    // The probe address comes from the neighbor's bracket.
    assign sum = {1'b0, i_lo} + {1'b0, i_hi};
    assign mid = sum[IW:1];
    assign act = (i_hi - i_lo) > IW'(1);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_adv) begin
            r_probe <= mem[mid];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lo  <= i_lo;
            r_hi  <= i_hi;
            r_mid <= mid;
            r_act <= act;
            r_x   <= i_x;
        end
    end

    // A probe above the query pulls the upper bound down, otherwise the lower bound up.
    assign step  = r_act && !r_ctl.oor;
    assign go_hi = r_probe > r_x;
    assign o_lo  = (step && !go_hi) ? r_mid : r_lo;
    assign o_hi  = (step && go_hi) ? r_mid : r_hi;
    assign o_x   = r_x;
    assign o_ctl = r_ctl;

endmodule

// ===== sv/ntns_pick.sv =====
// Nearest pick: reads the bracketing pair and compares the products in log terms.
module ntns_pick import ntns_pkg::*; #(
    parameter int NUM_NOTES = NUM_NOTES_DEF,
    parameter int FREQ_BITS = FREQ_BITS_DEF,
    localparam int IW = $clog2(NUM_NOTES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_wr_en,
    input  logic [IW-1:0]        i_wr_addr,
    input  logic [FREQ_BITS-1:0] i_wr_data,
    input  t_ctl                 i_ctl,
    input  logic [IW-1:0]        i_lo,
    input  logic [IW-1:0]        i_hi,
    input  logic [FREQ_BITS-1:0] i_x,
    output t_ctl                 o_ctl,
    output logic [FREQ_BITS-1:0] o_freq,
    output logic [IW-1:0]        o_idx,
    output logic                 o_busy
);

    logic [FREQ_BITS-1:0] mem [NUM_NOTES];

    t_ctl                   r1_ctl;
    logic [IW-1:0]          r1_lo;
    logic [IW-1:0]          r1_hi;
    logic [FREQ_BITS-1:0]   r1_x;
    logic [FREQ_BITS-1:0]   r1_flo;
    logic [FREQ_BITS-1:0]   r1_fhi;
    t_ctl                   r2_ctl;
    logic [IW-1:0]          r2_lo;
    logic [IW-1:0]          r2_hi;
    logic [FREQ_BITS-1:0]   r2_x;
    logic [FREQ_BITS-1:0]   r2_flo;
    logic [FREQ_BITS-1:0]   r2_fhi;
    logic [2*FREQ_BITS-1:0] r2_xx;
    logic [2*FREQ_BITS-1:0] r2_ff;
    logic                   pick_lo;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_adv) begin
            r1_flo <= mem[i_lo];
            r1_fhi <= mem[i_hi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
        end else if (i_adv) begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_lo  <= i_lo;
            r1_hi  <= i_hi;
            r1_x   <= i_x;
            r2_lo  <= r1_lo;
            r2_hi  <= r1_hi;
            r2_x   <= r1_x;
            r2_flo <= r1_flo;
            r2_fhi <= r1_fhi;
            r2_xx  <= (2*FREQ_BITS)'(r1_x) * (2*FREQ_BITS)'(r1_x);
            r2_ff  <= (2*FREQ_BITS)'(r1_flo) * (2*FREQ_BITS)'(r1_fhi);
        end
    end

    // A tie goes to the upper entry.
    assign pick_lo = r2_xx < r2_ff;
    assign o_freq  = r2_ctl.oor ? r2_x : (pick_lo ? r2_flo : r2_fhi);
    assign o_idx   = r2_ctl.oor ? '0 : (pick_lo ? r2_lo : r2_hi);
    assign o_ctl   = r2_ctl;
    assign o_busy  = r1_ctl.valid || r2_ctl.valid;

endmodule

// ===== sv/nearest_tuning_note_search_unit.sv =====
// Top level of the nearest tuning note search unit: entry stage, bisection chain, result register.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+---------------------------------------------
//  input   | i_in_valid  | o_in_ready  | i_opcode, i_note, i_freq
//  output  | o_out_valid | i_out_ready | o_mapped_freq, o_note_index, o_out_of_range
//
// A write item lands in every copy of the note table at once. A query item walks an entry
// stage, STEPS bisection cells (seven for 128 notes), two pick stages and the result
// register. The unit holds one item at a time in the chain; a new item is taken as soon
// as the previous query has moved into the result register, even while that result waits.
// A stall on the output freezes the whole chain. Reset is synchronous and active low; it
// clears only the control flags of the chain and the output valid bit, and the table
// stays undefined until written.
module nearest_tuning_note_search_unit import ntns_pkg::*; #(
    parameter int NUM_NOTES = NUM_NOTES_DEF,
    parameter int FREQ_BITS = FREQ_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_opcode,
    input  logic [NOTE_W-1:0]    i_note,
    input  logic [FREQ_BITS-1:0] i_freq,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [FREQ_BITS-1:0] o_mapped_freq,
    output logic [NOTE_W-1:0]    o_note_index,
    output logic                 o_out_of_range
);

    localparam int IW    = $clog2(NUM_NOTES);
    localparam int EW    = (IW > NOTE_W) ? IW : NOTE_W;
    // Number of probes needed to shrink the bracket [0, NUM_NOTES-1] to neighbors.
    localparam int STEPS = (NUM_NOTES > 2) ? $clog2(NUM_NOTES - 1) : 1;
    localparam logic [IW-1:0] LAST = IW'(NUM_NOTES - 1);

    logic                 in_acc;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic                 adv;
    logic                 busy;
    logic                 cells_busy;
    logic                 pick_busy;

    // The table ends are kept in registers so the span test needs no table read.
    logic [FREQ_BITS-1:0] r_first;
    logic [FREQ_BITS-1:0] r_last;

    // Entry stage.
    t_ctl                 r_s0_ctl;
    logic [FREQ_BITS-1:0] r_s0_x;
    logic                 n_oor;

    t_ctl                 c_ctl [STEPS+1];
    logic [IW-1:0]        c_lo  [STEPS+1];
    logic [IW-1:0]        c_hi  [STEPS+1];
    logic [FREQ_BITS-1:0] c_x   [STEPS+1];

    t_ctl                 pick_ctl;
    logic [FREQ_BITS-1:0] pick_freq;
    logic [IW-1:0]        pick_idx;
    logic [EW-1:0]        idx_ext;

    // Result register.
    logic                 r_out_valid;
    logic [FREQ_BITS-1:0] r_out_freq;
    logic [NOTE_W-1:0]    r_out_note;
    logic                 r_out_oor;

    assign adv        = !r_out_valid || i_out_ready;
    assign busy       = r_s0_ctl.valid || cells_busy || pick_busy;
    assign o_in_ready = !busy;
    assign in_acc     = i_in_valid && o_in_ready;
    // Writes beyond the table are dropped.
    assign wr_en      = in_acc && (i_opcode == OP_WRITE) && (int'(i_note) < NUM_NOTES);
    assign wr_addr    = IW'(i_note);
    assign n_oor      = (i_freq < r_first) || (r_last < i_freq);

    always_ff @(posedge i_clk) begin
        if (wr_en && (wr_addr == '0)) begin
            r_first <= i_freq;
        end
        if (wr_en && (wr_addr == LAST)) begin
            r_last <= i_freq;
        end
    end

    // The entry stage loads only when the chain is empty; it holds its item while the output stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl <= '0;
        end else if (in_acc) begin
            r_s0_ctl.valid <= (i_opcode == OP_QUERY);
            r_s0_ctl.oor   <= n_oor;
        end else if (adv) begin
            r_s0_ctl <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s0_x <= i_freq;
        end
    end

    assign c_ctl[0] = r_s0_ctl;
    assign c_lo[0]  = '0;
    assign c_hi[0]  = LAST;
    assign c_x[0]   = r_s0_x;

    // Each cell narrows the bracket by one probe and hands it to its neighbor.
    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        ntns_cell #(
            .NUM_NOTES (NUM_NOTES),
            .FREQ_BITS (FREQ_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (adv),
            .i_wr_en   (wr_en),
            .i_wr_addr (wr_addr),
            .i_wr_data (i_freq),
            .i_ctl     (c_ctl[k]),
            .i_lo      (c_lo[k]),
            .i_hi      (c_hi[k]),
            .i_x       (c_x[k]),
            .o_ctl     (c_ctl[k+1]),
            .o_lo      (c_lo[k+1]),
            .o_hi      (c_hi[k+1]),
            .o_x       (c_x[k+1])
        );
    end

    always_comb begin
        cells_busy = 1'b0;
        for (int k = 1; k <= STEPS; k++) begin
            cells_busy = cells_busy || c_ctl[k].valid;
        end
    end

    ntns_pick #(
        .NUM_NOTES (NUM_NOTES),
        .FREQ_BITS (FREQ_BITS)
    ) u_pick (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_freq),
        .i_ctl     (c_ctl[STEPS]),
        .i_lo      (c_lo[STEPS]),
        .i_hi      (c_hi[STEPS]),
        .i_x       (c_x[STEPS]),
        .o_ctl     (pick_ctl),
        .o_freq    (pick_freq),
        .o_idx     (pick_idx),
        .o_busy    (pick_busy)
    );

    // The reported index is the low seven bits of the table index.
    assign idx_ext = EW'(pick_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= pick_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_freq <= pick_freq;
            r_out_note <= idx_ext[NOTE_W-1:0];
            r_out_oor  <= pick_ctl.oor;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mapped_freq  = r_out_freq;
    assign o_note_index   = r_out_note;
    assign o_out_of_range = r_out_oor;

    // At most one item is ever in flight along the chain.
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_s0_ctl.valid, cells_busy, pick_busy}) <= 1)
        else $error("more than one item in the search chain");

    // An out-of-range result always carries index zero.
    a_oor_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> (o_note_index == '0))
        else $error("out-of-range result with nonzero index");

    // A result only appears when the pick stage held a query.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(pick_ctl.valid))
        else $error("result appeared without a query in the pick stage");

    // The table is never written while a query is reading it.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !$past(busy) || !busy)
        else $error("table write while a query is in flight");

endmodule
